[design/snvp_pkg.sv]
// Package for the section/name/value text parser.
// Holds the shared constants, parser modes, result codes and item types.
// Has no dependencies.
package snvp_pkg;

	localparam int MAX_ITEMS_DEF     = 32;
	localparam int SECTION_LIMIT_DEF = 34;
	localparam int NAME_LIMIT_DEF    = 16;
	localparam int VALUE_LIMIT_DEF   = 128;

	localparam int CHAR_W  = 8;
	localparam int CPOS_W  = 8;
	localparam int POS_W   = 7;
	localparam int REC_W   = 6;
	localparam int KIND_W  = 3;

	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

	localparam int MIN_RECORDS = 3;

	localparam logic [1:0] SKIP_AFTER_SECTION = 2'd2;
	localparam logic [1:0] SKIP_AFTER_BRACE   = 2'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_SKIP     = 3'd0,
		KIND_SECTION  = 3'd1,
		KIND_NAME     = 3'd2,
		KIND_VALUE    = 3'd3,
		KIND_RECORD   = 3'd4,
		KIND_OVERFLOW = 3'd5,
		KIND_IGNORED  = 3'd6
	} kind_t;

	typedef enum logic [6:0] {
		MODE_SECTION      = 7'b0000001,
		MODE_NAME         = 7'b0000010,
		MODE_VALUE        = 7'b0000100,
		MODE_CHECK        = 7'b0001000,
		MODE_SKIP_NAME    = 7'b0010000,
		MODE_SKIP_SECTION = 7'b0100000,
		MODE_STOPPED      = 7'b1000000
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [1:0]        skip_left;
		logic [CPOS_W-1:0] char_pos;
		logic              overflowed;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		mode:       MODE_SECTION,
		skip_left:  2'd0,
		char_pos:   '0,
		overflowed: 1'b0
	};

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] char_out;
		logic [POS_W-1:0]  position;
		logic [REC_W-1:0]  record_index;
		logic              done_res;
		logic [REC_W-1:0]  item_count;
	} out_item_t;

endpackage

[design/snvp_if.sv]
// Handshake channels of the section/name/value text parser.
// One interface for the byte stream and one for the tagged results.
// Depends on snvp_pkg for the field widths.
interface snvp_byte_if;
	logic                         valid;
	logic                         ready;
	logic [snvp_pkg::CHAR_W-1:0]  char_in;
	logic                         is_last;

	modport source (output valid, output char_in, output is_last, input ready);
	modport sink (input valid, input char_in, input is_last, output ready);
endinterface

interface snvp_tag_if;
	logic                         valid;
	logic                         ready;
	logic [snvp_pkg::KIND_W-1:0]  kind;
	logic [snvp_pkg::CHAR_W-1:0]  char_out;
	logic [snvp_pkg::POS_W-1:0]   position;
	logic [snvp_pkg::REC_W-1:0]   record_index;
	logic                         done_res;
	logic [snvp_pkg::REC_W-1:0]   item_count;

	modport source (output valid, output kind, output char_out, output position,
		output record_index, output done_res, output item_count, input ready);
	modport sink (input valid, input kind, input char_out, input position,
		input record_index, input done_res, input item_count, output ready);
endinterface

[design/section_name_value_text_parser.sv]
// Top level of the section/name/value text parser: input stage, tagger, result register.
// Depends on snvp_pkg, snvp_if and snvp_tagger.
//
//   channel   direction  payload
//   byte_ch   sink       char_in, is_last
//   tag_ch    source     kind, char_out, position, record_index, done_res, item_count
//
// One byte is accepted per cycle unless the result stalls; its tag goes on to the result register.
// The byte sits in the input register while the tagger reads the parse state, and the
// parse state and the result register are written together on the same edge.
// A stalled result holds the result register; the input register takes one more item
// and then holds ready low until the waiting result is taken.
// Reset clears the parse state, the record count and both valid flags.
module section_name_value_text_parser #(
	parameter int MAX_ITEMS     = snvp_pkg::MAX_ITEMS_DEF,
	parameter int SECTION_LIMIT = snvp_pkg::SECTION_LIMIT_DEF,
	parameter int NAME_LIMIT    = snvp_pkg::NAME_LIMIT_DEF,
	parameter int VALUE_LIMIT   = snvp_pkg::VALUE_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	snvp_byte_if.sink   byte_ch,
	snvp_tag_if.source  tag_ch
);

	localparam int RD_W = $clog2(MAX_ITEMS + 2);

	logic                          valid_s1;
	logic [snvp_pkg::CHAR_W-1:0]   char_s1;
	logic                          last_s1;
	snvp_pkg::parse_state_t        state_q;
	snvp_pkg::parse_state_t        state_nxt;
	logic [RD_W-1:0]               records_q;
	logic [RD_W-1:0]               records_nxt;
	logic                          out_valid_q;
	snvp_pkg::out_item_t           out_q;
	snvp_pkg::out_item_t           item;
	logic                          advance;

	assign advance       = valid_s1 && (!out_valid_q || tag_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			char_s1 <= byte_ch.char_in;
			last_s1 <= byte_ch.is_last;
		end
	end

	snvp_tagger #(
		.MAX_ITEMS     (MAX_ITEMS),
		.SECTION_LIMIT (SECTION_LIMIT),
		.NAME_LIMIT    (NAME_LIMIT),
		.VALUE_LIMIT   (VALUE_LIMIT),
		.RD_W          (RD_W)
	) u_tagger (
		.char_in     (char_s1),
		.is_last     (last_s1),
		.state       (state_q),
		.records     (records_q),
		.state_nxt   (state_nxt),
		.records_nxt (records_nxt),
		.item        (item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= snvp_pkg::STATE_RESET;
			records_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q   <= state_nxt;
				records_q <= records_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (tag_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= item;
		end
	end

	assign tag_ch.valid        = out_valid_q;
	assign tag_ch.kind         = out_q.kind;
	assign tag_ch.char_out     = out_q.char_out;
	assign tag_ch.position     = out_q.position;
	assign tag_ch.record_index = out_q.record_index;
	assign tag_ch.done_res     = out_q.done_res;
	assign tag_ch.item_count   = out_q.item_count;

endmodule

[design/snvp_tagger.sv]
// Combinational step of the parser: tags one byte and computes the next state.
// Depends on snvp_pkg for modes, result codes and item types.
module snvp_tagger #(
	parameter int MAX_ITEMS     = snvp_pkg::MAX_ITEMS_DEF,
	parameter int SECTION_LIMIT = snvp_pkg::SECTION_LIMIT_DEF,
	parameter int NAME_LIMIT    = snvp_pkg::NAME_LIMIT_DEF,
	parameter int VALUE_LIMIT   = snvp_pkg::VALUE_LIMIT_DEF,
	parameter int RD_W          = $clog2(MAX_ITEMS + 2)
) (
	input  logic [snvp_pkg::CHAR_W-1:0] char_in,
	input  logic                        is_last,
	input  snvp_pkg::parse_state_t      state,
	input  logic [RD_W-1:0]             records,
	output snvp_pkg::parse_state_t      state_nxt,
	output logic [RD_W-1:0]             records_nxt,
	output snvp_pkg::out_item_t         item
);

	localparam logic [snvp_pkg::CPOS_W-1:0] SEC_LIM = snvp_pkg::CPOS_W'(SECTION_LIMIT);
	localparam logic [snvp_pkg::CPOS_W-1:0] NAM_LIM = snvp_pkg::CPOS_W'(NAME_LIMIT);
	localparam logic [snvp_pkg::CPOS_W-1:0] VAL_LIM = snvp_pkg::CPOS_W'(VALUE_LIMIT);
	localparam logic [RD_W-1:0]             REC_MAX = RD_W'(MAX_ITEMS);
	localparam logic [RD_W-1:0]             REC_MIN = RD_W'(snvp_pkg::MIN_RECORDS);

	snvp_pkg::parse_state_t         st;
	logic [RD_W-1:0]                rd;
	snvp_pkg::kind_t                kind;
	logic [snvp_pkg::CHAR_W-1:0]    cout;
	logic [snvp_pkg::CPOS_W-1:0]    pos;
	logic [snvp_pkg::CPOS_W-1:0]    name_base;
	logic [1:0]                     left;

	always_comb begin
		st        = state;
		rd        = records;
		kind      = snvp_pkg::KIND_IGNORED;
		cout      = '0;
		pos       = '0;
		name_base = '0;
		left      = '0;
		if (state.mode == snvp_pkg::MODE_STOPPED || char_in == snvp_pkg::CH_NUL) begin
			st.mode = snvp_pkg::MODE_STOPPED;
		end else begin
			unique case (state.mode) inside
				snvp_pkg::MODE_SECTION: begin
					if (char_in != snvp_pkg::CH_LF && state.char_pos < SEC_LIM) begin
						kind        = snvp_pkg::KIND_SECTION;
						cout        = char_in;
						pos         = state.char_pos;
						st.char_pos = state.char_pos + 1'b1;
					end else begin
						kind         = snvp_pkg::KIND_SKIP;
						st.char_pos  = '0;
						st.mode      = snvp_pkg::MODE_SKIP_NAME;
						st.skip_left = snvp_pkg::SKIP_AFTER_SECTION;
					end
				end
				snvp_pkg::MODE_CHECK, snvp_pkg::MODE_NAME: begin
					name_base = (state.mode == snvp_pkg::MODE_CHECK) ? '0 : state.char_pos;
					if (state.mode == snvp_pkg::MODE_CHECK && char_in == snvp_pkg::CH_RBRACE) begin
						kind         = snvp_pkg::KIND_SKIP;
						st.mode      = snvp_pkg::MODE_SKIP_SECTION;
						st.skip_left = snvp_pkg::SKIP_AFTER_BRACE;
					end else if (char_in != snvp_pkg::CH_EQUAL && char_in != snvp_pkg::CH_BANG
							&& name_base < NAM_LIM) begin
						kind        = snvp_pkg::KIND_NAME;
						cout        = char_in;
						pos         = name_base;
						st.char_pos = name_base + 1'b1;
						st.mode     = snvp_pkg::MODE_NAME;
					end else begin
						kind        = snvp_pkg::KIND_SKIP;
						st.char_pos = '0;
						st.mode     = snvp_pkg::MODE_VALUE;
					end
				end
				snvp_pkg::MODE_VALUE: begin
					if (char_in != snvp_pkg::CH_LF && state.char_pos < VAL_LIM) begin
						kind        = snvp_pkg::KIND_VALUE;
						cout        = char_in;
						pos         = state.char_pos;
						st.char_pos = state.char_pos + 1'b1;
					end else begin
						st.char_pos = '0;
						if (records > REC_MAX) begin
							kind          = snvp_pkg::KIND_OVERFLOW;
							st.overflowed = 1'b1;
							st.mode       = snvp_pkg::MODE_STOPPED;
						end else begin
							kind    = snvp_pkg::KIND_RECORD;
							rd      = records + 1'b1;
							st.mode = snvp_pkg::MODE_CHECK;
						end
					end
				end
				snvp_pkg::MODE_SKIP_NAME, snvp_pkg::MODE_SKIP_SECTION: begin
					kind         = snvp_pkg::KIND_SKIP;
					left         = state.skip_left - {1'b0, (state.skip_left != 2'd0)};
					st.skip_left = left;
					if (left == 2'd0) begin
						st.char_pos = '0;
						st.mode     = (state.mode == snvp_pkg::MODE_SKIP_NAME)
							? snvp_pkg::MODE_NAME : snvp_pkg::MODE_SECTION;
					end
				end
				default: begin
					st.mode = snvp_pkg::MODE_STOPPED;
				end
			endcase
		end
	end

	always_comb begin
		item.kind         = kind;
		item.char_out     = cout;
		item.position     = pos[snvp_pkg::POS_W-1:0];
		item.record_index = snvp_pkg::REC_W'(records);
		item.done_res     = is_last;
		item.item_count   = '0;
		if (is_last && !st.overflowed && rd >= REC_MIN) begin
			item.item_count = snvp_pkg::REC_W'(rd);
		end
	end

	assign state_nxt   = is_last ? snvp_pkg::STATE_RESET : st;
	assign records_nxt = is_last ? '0 : rd;

endmodule

[design/snvp_checker.sv]
// Port-level checks for the section/name/value text parser, bound to its top level.
// Depends on snvp_pkg for result codes and field widths.
module snvp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [snvp_pkg::KIND_W-1:0] kind,
	input logic [snvp_pkg::CHAR_W-1:0] char_out,
	input logic [snvp_pkg::POS_W-1:0]  position,
	input logic                        done_res,
	input logic [snvp_pkg::REC_W-1:0]  item_count
);

	logic stored;

	assign stored = kind == snvp_pkg::KIND_SECTION || kind == snvp_pkg::KIND_NAME
		|| kind == snvp_pkg::KIND_VALUE;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_out))
		else $error("result changed while stalled");

	a_count_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> item_count == '0)
		else $error("record count shown before the last byte");

	a_unstored_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stored |-> char_out == '0 && position == '0)
		else $error("byte or position shown for a non-stored tag");

	a_no_zero_stored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stored |-> char_out != snvp_pkg::CH_NUL)
		else $error("zero byte tagged as stored text");

endmodule

bind section_name_value_text_parser snvp_checker u_snvp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (tag_ch.valid),
	.out_ready  (tag_ch.ready),
	.kind       (tag_ch.kind),
	.char_out   (tag_ch.char_out),
	.position   (tag_ch.position),
	.done_res   (tag_ch.done_res),
	.item_count (tag_ch.item_count)
);

[sim/section_name_value_text_parser_tb.sv]
`timescale 1ns / 1ps
// Testbench for section_name_value_text_parser: streams whole messages and checks every tag.
// Depends on snvp_pkg, snvp_if and the parser RTL; expected tags come from an in-bench tagger.
module section_name_value_text_parser_tb;

	localparam int SEC_LIM     = snvp_pkg::SECTION_LIMIT_DEF;
	localparam int NAME_LIM    = snvp_pkg::NAME_LIMIT_DEF;
	localparam int VAL_LIM     = snvp_pkg::VALUE_LIMIT_DEF;
	localparam int REC_MAX     = snvp_pkg::MAX_ITEMS_DEF;
	localparam int ITEM_TARGET = 250;
	localparam int IDLE_LIMIT  = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	snvp_byte_if byte_ch ();
	snvp_tag_if  tag_ch ();

	section_name_value_text_parser #(
		.MAX_ITEMS     (REC_MAX),
		.SECTION_LIMIT (SEC_LIM),
		.NAME_LIMIT    (NAME_LIM),
		.VALUE_LIMIT   (VAL_LIM)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.tag_ch  (tag_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	snvp_pkg::mode_t             cur_mode      = snvp_pkg::MODE_SECTION;
	logic [1:0]                  skip_count    = 2'd0;
	logic [snvp_pkg::CPOS_W-1:0] char_count    = '0;
	logic [snvp_pkg::REC_W-1:0]  records_seen  = '0;
	logic                        overflow_seen = 1'b0;

	snvp_pkg::out_item_t expected_tags[$];
	logic [7:0]  msg_bytes[$];
	int          errors       = 0;
	int          items_sent   = 0;
	int          idle_cycles  = 0;
	int          stall_left   = 0;
	int          run_left     = 0;
	bit          no_gaps      = 1'b0;

	function automatic snvp_pkg::out_item_t tag_byte(input logic [7:0] ch, input logic last);
		snvp_pkg::out_item_t r;
		bit brace_entry;
		r = '0;
		r.kind = snvp_pkg::KIND_IGNORED;
		brace_entry = 1'b0;
		if (cur_mode == snvp_pkg::MODE_STOPPED) begin
			r.kind = snvp_pkg::KIND_IGNORED;
		end else if (ch == snvp_pkg::CH_NUL) begin
			cur_mode = snvp_pkg::MODE_STOPPED;
		end else begin
			if (cur_mode == snvp_pkg::MODE_CHECK) begin
				if (ch == snvp_pkg::CH_RBRACE) begin
					cur_mode = snvp_pkg::MODE_SKIP_SECTION;
					skip_count = snvp_pkg::SKIP_AFTER_BRACE;
					r.kind = snvp_pkg::KIND_SKIP;
					brace_entry = 1'b1;
				end else begin
					cur_mode = snvp_pkg::MODE_NAME;
					char_count = '0;
				end
			end
			if (!brace_entry) begin
				case (cur_mode) inside
					snvp_pkg::MODE_SECTION: begin
						if (ch != snvp_pkg::CH_LF && char_count < SEC_LIM) begin
							r.kind = snvp_pkg::KIND_SECTION;
							r.char_out = ch;
							r.position = char_count[snvp_pkg::POS_W-1:0];
							char_count++;
						end else begin
							r.kind = snvp_pkg::KIND_SKIP;
							char_count = '0;
							cur_mode = snvp_pkg::MODE_SKIP_NAME;
							skip_count = snvp_pkg::SKIP_AFTER_SECTION;
						end
					end
					snvp_pkg::MODE_NAME: begin
						if (ch != snvp_pkg::CH_EQUAL && ch != snvp_pkg::CH_BANG
								&& char_count < NAME_LIM) begin
							r.kind = snvp_pkg::KIND_NAME;
							r.char_out = ch;
							r.position = char_count[snvp_pkg::POS_W-1:0];
							char_count++;
						end else begin
							r.kind = snvp_pkg::KIND_SKIP;
							char_count = '0;
							cur_mode = snvp_pkg::MODE_VALUE;
						end
					end
					snvp_pkg::MODE_VALUE: begin
						if (ch != snvp_pkg::CH_LF && char_count < VAL_LIM) begin
							r.kind = snvp_pkg::KIND_VALUE;
							r.char_out = ch;
							r.position = char_count[snvp_pkg::POS_W-1:0];
							char_count++;
						end else begin
							char_count = '0;
							if (records_seen > REC_MAX) begin
								r.kind = snvp_pkg::KIND_OVERFLOW;
								overflow_seen = 1'b1;
								cur_mode = snvp_pkg::MODE_STOPPED;
							end else begin
								r.kind = snvp_pkg::KIND_RECORD;
								r.record_index = records_seen;
								records_seen++;
								cur_mode = snvp_pkg::MODE_CHECK;
							end
						end
					end
					snvp_pkg::MODE_SKIP_NAME, snvp_pkg::MODE_SKIP_SECTION: begin
						r.kind = snvp_pkg::KIND_SKIP;
						if (skip_count > 0)
							skip_count--;
						if (skip_count == 0) begin
							cur_mode = (cur_mode == snvp_pkg::MODE_SKIP_NAME)
								? snvp_pkg::MODE_NAME : snvp_pkg::MODE_SECTION;
							char_count = '0;
						end
					end
					default: ;
				endcase
			end
		end
		if (r.kind != snvp_pkg::KIND_RECORD)
			r.record_index = records_seen;
		r.done_res = last;
		if (last) begin
			r.item_count = (overflow_seen || records_seen < snvp_pkg::MIN_RECORDS)
				? '0 : records_seen;
			cur_mode = snvp_pkg::MODE_SECTION;
			skip_count = 2'd0;
			char_count = '0;
			records_seen = '0;
			overflow_seen = 1'b0;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		if (b == snvp_pkg::CH_LF || b == snvp_pkg::CH_EQUAL || b == snvp_pkg::CH_BANG
				|| b == snvp_pkg::CH_RBRACE)
			b = b + 8'd1;
		return b;
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 9))
			0: return snvp_pkg::CH_NUL;
			1: return snvp_pkg::CH_LF;
			2: return snvp_pkg::CH_EQUAL;
			3: return snvp_pkg::CH_BANG;
			4: return snvp_pkg::CH_RBRACE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_len(input int limit, input int short_max, input int pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < pct)
			return limit;
		if (r < 2 * pct)
			return limit - 1;
		return $urandom_range(0, short_max);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			tag_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			tag_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			tag_ch.ready <= 1'b1;
			if (run_left > 0) begin
				run_left--;
			end else begin
				stall_left = pick_gap();
				run_left = $urandom_range(0, 6);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready)
			expected_tags.push_back(tag_byte(byte_ch.char_in, byte_ch.is_last));
	end

	task automatic check_tag();
		snvp_pkg::out_item_t exp;
		if (expected_tags.size() == 0) begin
			$error("unexpected result item: kind %0d record_index %0d",
				tag_ch.kind, tag_ch.record_index);
			errors++;
		end else begin
			exp = expected_tags.pop_front();
			if (tag_ch.kind !== exp.kind) begin
				$error("kind: expected %0d, got %0d", exp.kind, tag_ch.kind);
				errors++;
			end
			if (tag_ch.char_out !== exp.char_out) begin
				$error("char_out: expected %0d, got %0d", exp.char_out, tag_ch.char_out);
				errors++;
			end
			if (tag_ch.position !== exp.position) begin
				$error("position: expected %0d, got %0d", exp.position, tag_ch.position);
				errors++;
			end
			if (tag_ch.record_index !== exp.record_index) begin
				$error("record_index: expected %0d, got %0d", exp.record_index,
					tag_ch.record_index);
				errors++;
			end
			if (tag_ch.done_res !== exp.done_res) begin
				$error("done_res: expected %0d, got %0d", exp.done_res, tag_ch.done_res);
				errors++;
			end
			if (tag_ch.item_count !== exp.item_count) begin
				$error("item_count: expected %0d, got %0d", exp.item_count, tag_ch.item_count);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && tag_ch.valid && tag_ch.ready)
			check_tag();
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (tag_ch.valid && tag_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("section_name_value_text_parser test failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] ch, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.char_in <= ch;
		byte_ch.is_last <= last;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		msg_bytes.delete();
	endtask

	task automatic add_text(input int n);
		repeat (n) msg_bytes.push_back(text_byte());
	endtask

	// A section line at the limit is closed by whatever byte follows it.
	task automatic add_section(input int len);
		add_text(len);
		msg_bytes.push_back(len == SEC_LIM ? any_byte() : snvp_pkg::CH_LF);
		msg_bytes.push_back(any_byte());
		msg_bytes.push_back(any_byte());
	endtask

	task automatic add_record(input int name_len, input int value_len);
		add_text(name_len);
		if (name_len == NAME_LIM)
			msg_bytes.push_back(any_byte());
		else
			msg_bytes.push_back($urandom_range(0, 1) ? snvp_pkg::CH_EQUAL : snvp_pkg::CH_BANG);
		add_text(value_len);
		msg_bytes.push_back(value_len == VAL_LIM ? any_byte() : snvp_pkg::CH_LF);
	endtask

	task automatic add_brace();
		msg_bytes.push_back(snvp_pkg::CH_RBRACE);
		msg_bytes.push_back(any_byte());
	endtask

	task automatic add_wellformed();
		int nrec;
		add_section(pick_len(SEC_LIM, 8, 5));
		nrec = $urandom_range(0, 6);
		for (int i = 0; i < nrec; i++) begin
			if (i > 0 && $urandom_range(0, 4) == 0) begin
				add_brace();
				add_section(pick_len(SEC_LIM, 8, 5));
			end
			add_record(pick_len(NAME_LIM, 6, 5), pick_len(VAL_LIM, 10, 1));
		end
		if ($urandom_range(0, 3) == 0)
			add_text($urandom_range(1, 3));
	endtask

	task automatic run_directed_tags();
		msg_bytes = '{8'hFF, snvp_pkg::CH_LF, 8'h01, 8'h80, 8'h7F, snvp_pkg::CH_EQUAL, 8'hFE,
			snvp_pkg::CH_LF, 8'h6B, snvp_pkg::CH_BANG, snvp_pkg::CH_LF, snvp_pkg::CH_RBRACE,
			8'h20, 8'h01, snvp_pkg::CH_LF, 8'h55, 8'hAA, snvp_pkg::CH_EQUAL, snvp_pkg::CH_LF,
			8'h41, snvp_pkg::CH_NUL, 8'hFF};
		send_message();
		msg_bytes = '{snvp_pkg::CH_NUL};
		send_message();
		msg_bytes = '{snvp_pkg::CH_LF, snvp_pkg::CH_LF};
		send_message();
	endtask

	task automatic run_field_limits();
		add_section(SEC_LIM);
		add_record(NAME_LIM, 0);
		add_record(NAME_LIM - 1, VAL_LIM);
		add_record(0, VAL_LIM - 1);
		send_message();
		add_section(SEC_LIM - 1);
		add_record(1, 1);
		add_brace();
		add_section(0);
		add_record(NAME_LIM, 2);
		send_message();
	endtask

	task automatic run_record_overflow();
		int counts[4] = '{2, 3, REC_MAX + 1, REC_MAX + 2};
		foreach (counts[i]) begin
			add_section($urandom_range(0, 4));
			repeat (counts[i]) add_record($urandom_range(0, 1), $urandom_range(0, 1));
			if ($urandom_range(0, 1))
				msg_bytes.push_back(any_byte());
			send_message();
		end
	endtask

	task automatic run_random_messages();
		int start;
		int r;
		int keep;
		start = items_sent;
		while (items_sent - start < ITEM_TARGET) begin
			no_gaps = ($urandom_range(0, 9) == 0);
			r = $urandom_range(0, 99);
			if (r < 60) begin
				add_wellformed();
			end else if (r < 78) begin
				add_wellformed();
				keep = $urandom_range(1, msg_bytes.size());
				while (msg_bytes.size() > keep)
					void'(msg_bytes.pop_back());
				if ($urandom_range(0, 1))
					msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = snvp_pkg::CH_NUL;
			end else if (r < 92) begin
				repeat ($urandom_range(1, 24)) msg_bytes.push_back(noise_byte());
			end else begin
				add_section($urandom_range(0, 3));
				repeat ($urandom_range(REC_MAX - 2, REC_MAX + 3))
					add_record($urandom_range(0, 2), $urandom_range(0, 2));
			end
			send_message();
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		byte_ch.valid = 1'b0;
		byte_ch.char_in = '0;
		byte_ch.is_last = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed_tags();
		run_field_limits();
		run_record_overflow();
		run_random_messages();
		byte_ch.valid <= 1'b0;
		while (expected_tags.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("section_name_value_text_parser test passed");
		else
			$display("section_name_value_text_parser test failed");
		$finish;
	end

endmodule

[section_name_value_text_parser.f]
design/snvp_pkg.sv
design/snvp_if.sv
design/snvp_tagger.sv
design/section_name_value_text_parser.sv
design/snvp_checker.sv
sim/section_name_value_text_parser_tb.sv
